### rtl/dbsr_pkg.sv
// Package for the dense bitmap successor/rank block.
// Sizes, derived index widths and the group reciprocal constant.
// No dependencies.
`timescale 1ns / 1ps
package dbsr_pkg;

   localparam int WORDS      = 1024;
   localparam int GROUP_BITS = 512;

   localparam int WORD_BITS  = 64;
   localparam int POS_W      = 6;
   localparam int WPG        = (GROUP_BITS / 64) > 0 ? (GROUP_BITS / 64) : 1;
   localparam int NGROUPS    = (WORDS + WPG - 1) / WPG;

   localparam int WIDX       = $clog2(WORDS);
   localparam int GIDX       = NGROUPS > 1 ? $clog2(NGROUPS) : 1;
   localparam int CNT_W      = 17;
   localparam int PFX_W      = 16;

   // ceil(2^RECIP_SH / WPG): exact quotient for every word index below 2^12
   localparam int RECIP_SH   = 24;
   localparam int RECIP      = ((1 << RECIP_SH) + WPG - 1) / WPG;
   localparam int RECIP_W    = RECIP_SH + 1;
   localparam int PROD_W     = WIDX + RECIP_W;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   typedef struct packed {
      logic [31:0] acc;
      logic [63:0] word;
      logic [63:0] mask;
   } popacc_req_type;

endpackage

### rtl/dbsr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dbsr_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dbsr_popacc.sv
// Shared masked population count and accumulate unit.
// Depends on dbsr_pkg.
`timescale 1ns / 1ps
module dbsr_popacc (
   input  dbsr_pkg::popacc_req_type req,
   output logic [31:0]              sum
);
   import dbsr_pkg::*;

   logic [63:0] bits;
   logic [6:0]  count;

   always_comb begin
      bits  = req.word & req.mask;
      count = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         count = count + 7'(bits[i]);
      end
      sum = req.acc + 32'(count);
   end

endmodule

### rtl/dense_bitmap_successor_rank.sv
// Usage:
//   Slave channel req_*: one word per item. req_tuser[0] is func: load
//   (0) stores req_tdata word_value as the next bitmap word, in order from
//   word 0, wrapping after the last word; query (1) searches from target.
//   Master channel rsp_*: one word per query, none per load. rsp_tuser[0]
//   is found; rsp_tdata holds doc (low 32 bits) and rank (high 32 bits).
// Flow:
//   A load is taken in S_IDLE, which it does not leave, so req_tready stays high.
//   A query scans the bitmap RAM one word per cycle from the target word
//   until a nonzero word, then reads the group prefix and counts the
//   earlier words of that group one word per cycle through the shared
//   popcount unit.
//   req_tready is low while a query is in flight.
// Reset:
//   Clears the load pointer, running count and the handshake state.
//   Bitmap and prefix RAMs are not cleared; load the block before a query.
// Stall:
//   A stalled result is held in the output register; loads are still
//   taken, and a finished query waits for the register to empty.
`timescale 1ns / 1ps
module dense_bitmap_successor_rank (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // word_value[63:0], target[79:64], block_number[95:80], base_rank[127:96]
   input  logic [127:0]  req_tdata,
   // func[0]
   input  logic [0:0]    req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // doc[31:0], rank[63:32]
   output logic [63:0]   rsp_tdata,
   // found[0]
   output logic [0:0]    rsp_tuser
);
   import dbsr_pkg::*;

   localparam int OFFW = WPG > 1 ? $clog2(WPG) : 1;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_DIV, S_GRP, S_PREF, S_RANK, S_RESP
   } state_type;

   function automatic logic [POS_W-1:0] low_zeros(input logic [63:0] v);
      logic [POS_W-1:0] n;
      n = 6'd63;
      for (int i = 63; i >= 0; i--) begin
         if (v[i]) begin
            n = 6'(i);
         end
      end
      return n;
   endfunction

   state_type        state_ff, state_in;
   logic [WIDX-1:0]  load_ptr_ff, load_ptr_in;
   logic [OFFW-1:0]  load_off_ff, load_off_in;
   logic [GIDX-1:0]  load_grp_ff, load_grp_in;
   logic [CNT_W-1:0] load_cnt_ff, load_cnt_in;

   logic [WIDX-1:0]  w_ff, w_in;
   logic [POS_W-1:0] bit_ff, bit_in;
   logic             first_ff, first_in;
   logic [15:0]      block_ff, block_in;
   logic [31:0]      base_ff, base_in;
   logic [WIDX-1:0]  hit_w_ff, hit_w_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic             hit_ff, hit_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [WIDX-1:0]  k_ff, k_in;
   logic [31:0]      acc_ff, acc_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [63:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_found_ff, rsp_found_in;

   logic [63:0]      req_word;
   logic [15:0]      req_target;
   logic [15:0]      req_block;
   logic [31:0]      req_base;
   logic             req_fire;
   logic [9:0]       tgt_word;

   logic             bm_we, bm_re;
   logic [WIDX-1:0]  bm_waddr, bm_raddr;
   logic [63:0]      bm_rdata;
   logic             pf_we, pf_re;
   logic [GIDX-1:0]  pf_waddr, pf_raddr;
   logic [PFX_W-1:0] pf_wdata, pf_rdata;

   popacc_req_type   pa_req;
   logic [31:0]      pa_sum;
   logic [CNT_W-1:0] load_run;
   logic [63:0]      cur;
   logic [GIDX-1:0]  grp;
   logic [WIDX+POS_W-1:0] pos_full;

   assign req_word   = req_tdata[63:0];
   assign req_target = req_tdata[79:64];
   assign req_block  = req_tdata[95:80];
   assign req_base   = req_tdata[127:96];
   assign tgt_word   = req_target[15:6];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign load_run = (load_ptr_ff == '0) ? '0 : load_cnt_ff;
   assign cur      = bm_rdata & ({64{1'b1}} << (first_ff ? bit_ff : 6'd0));
   assign grp      = GIDX'(prod_ff >> RECIP_SH);
   assign pos_full = {hit_w_ff, pos_ff};

   always_comb begin
      if (state_ff == S_RANK) begin
         pa_req.acc  = acc_ff;
         pa_req.word = bm_rdata;
         pa_req.mask = (k_ff == hit_w_ff) ? ((64'd1 << pos_ff) - 64'd1) : {64{1'b1}};
      end else begin
         pa_req.acc  = 32'(load_run);
         pa_req.word = req_word;
         pa_req.mask = {64{1'b1}};
      end
   end

   dbsr_popacc u_popacc (
      .req (pa_req),
      .sum (pa_sum)
   );

   dbsr_ram #(
      .WIDTH (64),
      .DEPTH (WORDS)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bm_we),
      .wr_addr (bm_waddr),
      .wr_data (req_word),
      .rd_en   (bm_re),
      .rd_addr (bm_raddr),
      .rd_data (bm_rdata)
   );

   dbsr_ram #(
      .WIDTH (PFX_W),
      .DEPTH (NGROUPS)
   ) u_prefix_ram (
      .clock   (clock),
      .wr_en   (pf_we),
      .wr_addr (pf_waddr),
      .wr_data (pf_wdata),
      .rd_en   (pf_re),
      .rd_addr (pf_raddr),
      .rd_data (pf_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      load_ptr_in  = load_ptr_ff;
      load_off_in  = load_off_ff;
      load_grp_in  = load_grp_ff;
      load_cnt_in  = load_cnt_ff;
      w_in         = w_ff;
      bit_in       = bit_ff;
      first_in     = first_ff;
      block_in     = block_ff;
      base_in      = base_ff;
      hit_w_in     = hit_w_ff;
      pos_in       = pos_ff;
      hit_in       = hit_ff;
      prod_in      = prod_ff;
      k_in         = k_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;

      bm_we    = 1'b0;
      bm_waddr = load_ptr_ff;
      bm_re    = 1'b0;
      bm_raddr = w_ff + WIDX'(1);
      pf_we    = 1'b0;
      pf_waddr = load_grp_ff;
      pf_wdata = load_run[PFX_W-1:0];
      pf_re    = 1'b0;
      pf_raddr = grp;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && req_tuser[0] == FUNC_LOAD) begin
               bm_we       = 1'b1;
               pf_we       = (load_off_ff == '0);
               load_cnt_in = pa_sum[CNT_W-1:0];
               if (load_ptr_ff == WIDX'(WORDS - 1)) begin
                  load_ptr_in = '0;
                  load_off_in = '0;
                  load_grp_in = '0;
               end else begin
                  load_ptr_in = load_ptr_ff + WIDX'(1);
                  if (load_off_ff == OFFW'(WPG - 1)) begin
                     load_off_in = '0;
                     load_grp_in = load_grp_ff + GIDX'(1);
                  end else begin
                     load_off_in = load_off_ff + OFFW'(1);
                  end
               end
            end else if (req_fire) begin
               block_in = req_block;
               base_in  = req_base;
               bit_in   = req_target[5:0];
               w_in     = WIDX'(tgt_word);
               first_in = 1'b1;
               if (13'(tgt_word) >= 13'(WORDS)) begin
                  hit_in   = 1'b0;
                  state_in = S_RESP;
               end else begin
                  bm_re    = 1'b1;
                  bm_raddr = WIDX'(tgt_word);
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            first_in = 1'b0;
            if (cur != '0) begin
               hit_w_in = w_ff;
               pos_in   = low_zeros(cur);
               hit_in   = 1'b1;
               state_in = S_DIV;
            end else if (w_ff == WIDX'(WORDS - 1)) begin
               hit_in   = 1'b0;
               state_in = S_RESP;
            end else begin
               bm_re = 1'b1;
               w_in  = w_ff + WIDX'(1);
            end
         end
         S_DIV: begin
            prod_in  = PROD_W'(hit_w_ff) * PROD_W'(RECIP);
            state_in = S_GRP;
         end
         S_GRP: begin
            pf_re    = 1'b1;
            k_in     = WIDX'(32'(grp) * 32'(WPG));
            state_in = S_PREF;
         end
         S_PREF: begin
            acc_in   = base_ff + 32'(pf_rdata);
            bm_re    = 1'b1;
            bm_raddr = k_ff;
            state_in = S_RANK;
         end
         S_RANK: begin
            acc_in = pa_sum;
            if (k_ff == hit_w_ff) begin
               state_in = S_RESP;
            end else begin
               bm_re    = 1'b1;
               bm_raddr = k_ff + WIDX'(1);
               k_in     = k_ff + WIDX'(1);
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = hit_ff;
               if (hit_ff) begin
                  rsp_data_in = {acc_ff, {block_ff, 16'h0000} + 32'(pos_full)};
               end else begin
                  rsp_data_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         load_ptr_ff  <= '0;
         load_off_ff  <= '0;
         load_grp_ff  <= '0;
         load_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_ptr_ff  <= load_ptr_in;
         load_off_ff  <= load_off_in;
         load_grp_ff  <= load_grp_in;
         load_cnt_ff  <= load_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      w_ff         <= w_in;
      bit_ff       <= bit_in;
      first_ff     <= first_in;
      block_ff     <= block_in;
      base_ff      <= base_in;
      hit_w_ff     <= hit_w_in;
      pos_ff       <= pos_in;
      hit_ff       <= hit_in;
      prod_ff      <= prod_in;
      k_ff         <= k_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_found_ff;

`ifndef NO_ASSERTIONS
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 64'd0)
      else $error("not-found word carries nonzero data");

   a_rank_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RANK |-> k_ff <= hit_w_ff)
      else $error("rank walk passed the hit word");

   a_load_wrap: assert property (@(posedge clock) disable iff (reset)
      load_ptr_ff == '0 |-> load_off_ff == '0 && load_grp_ff == '0)
      else $error("group counters out of step with load pointer");
`endif

endmodule

### test/dense_bitmap_successor_rank_tb.sv
// Self-checking testbench for dense_bitmap_successor_rank: loads bitmap words, asks
// successor queries and checks doc, rank and found against an in-bench predictor.
// Depends on dbsr_pkg and the RTL of the block only.
`timescale 1ns / 1ps
module dense_bitmap_successor_rank_tb;
   import dbsr_pkg::*;

   localparam int RUN_LIMIT   = 5_000_000;
   localparam int RANDOM_MIX  = 48;
   localparam int TAIL_CYCLES = 1100;

   typedef struct packed {
      logic        found;
      logic [31:0] doc;
      logic [31:0] rank;
   } successor_type;

   typedef enum {WK_ZERO, WK_ONEHOT, WK_DENSE, WK_FULL, WK_SPARSE} word_kind_type;
   typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_TRICKLE} stall_mode_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   // word_value[63:0], target[79:64], block_number[95:80], base_rank[127:96]
   logic [127:0] req_tdata  = '0;
   // func[0]
   logic [0:0]   req_tuser  = FUNC_LOAD;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   // doc[31:0], rank[63:32]
   logic [63:0]  rsp_tdata;
   // found[0]
   logic [0:0]   rsp_tuser;

   // predictor state
   logic [63:0]      bitmap_mirror [WORDS];
   logic [PFX_W-1:0] group_base [NGROUPS];
   int unsigned      next_word = 0;
   logic [CNT_W-1:0] loaded_ones = '0;
   successor_type    pending_hits [$];

   int fail_count   = 0;
   int loads_sent   = 0;
   int queries_sent = 0;
   int hits_seen    = 0;
   int wraps_seen   = 0;
   int cycle_count  = 0;
   int burst_left   = 0;
   int hold_request = 0;
   int hold_left    = 0;
   int mode_left    = 0;
   stall_mode_type stall_mode = RX_OPEN;

   dense_bitmap_successor_rank dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > RUN_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void store_word(logic [63:0] value);
      if (next_word == 0) begin
         loaded_ones = '0;
         wraps_seen++;
      end
      if (next_word % WPG == 0)
         group_base[next_word / WPG] = loaded_ones[PFX_W-1:0];
      bitmap_mirror[next_word] = value;
      loaded_ones = loaded_ones + CNT_W'($countones(value));
      next_word = (next_word + 1) % WORDS;
   endfunction

   function automatic successor_type successor_of(logic [15:0] tgt, logic [15:0] blk,
                                                  logic [31:0] base);
      successor_type r;
      int unsigned w;
      int unsigned g;
      int unsigned k;
      int unsigned pos;
      logic [63:0] cur;
      logic [31:0] acc;
      r = '0;
      w = int'(tgt) / WORD_BITS;
      if (w >= WORDS)
         return r;
      cur = bitmap_mirror[w] & ({64{1'b1}} << tgt[5:0]);
      while (cur == '0) begin
         w++;
         if (w >= WORDS)
            return r;
         cur = bitmap_mirror[w];
      end
      pos = 0;
      while (!cur[pos])
         pos++;
      g = w / WPG;
      acc = base + 32'(group_base[g % NGROUPS]);
      for (k = g * WPG; k < w; k++)
         acc += 32'($countones(bitmap_mirror[k]));
      acc += 32'($countones(bitmap_mirror[w] & ((64'd1 << pos) - 64'd1)));
      r.found = 1'b1;
      r.doc   = (32'(blk) << 16) + 32'(w * WORD_BITS + pos);
      r.rank  = acc;
      return r;
   endfunction

   function automatic logic [63:0] shaped_word(word_kind_type kind);
      case (kind)
         WK_ZERO:   return '0;
         WK_ONEHOT: return 64'd1 << $urandom_range(0, 63);
         WK_FULL:   return '1;
         WK_SPARSE: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
         default:   return {$urandom, $urandom};
      endcase
   endfunction

   function automatic word_kind_type any_kind();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3)
         return WK_ZERO;
      else if (r == 3)
         return WK_ONEHOT;
      else if (r == 4)
         return WK_FULL;
      else if (r < 7)
         return WK_SPARSE;
      else
         return WK_DENSE;
   endfunction

   task automatic send_word(input logic fn, input logic [63:0] value, input logic [15:0] tgt,
                            input logic [15:0] blk, input logic [31:0] base);
      int gap;
      successor_type hit;
      req_tvalid <= 1'b1;
      req_tuser  <= fn;
      req_tdata  <= {base, blk, tgt, value};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (fn == FUNC_QUERY) begin
         hit = successor_of(tgt, blk, base);
         pending_hits.push_back(hit);
         queries_sent++;
         if (hit.found)
            hits_seen++;
      end else begin
         store_word(value);
         loads_sent++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 :
               $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 4);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic put_load(input logic [63:0] value);
      send_word(FUNC_LOAD, value, 16'($urandom), 16'($urandom), $urandom);
   endtask

   task automatic ask(input logic [15:0] tgt, input logic [15:0] blk, input logic [31:0] base);
      send_word(FUNC_QUERY, {$urandom, $urandom}, tgt, blk, base);
   endtask

   task automatic ask_random();
      logic [15:0] tgt;
      logic [31:0] base;
      case ($urandom_range(0, 3))
         0:       tgt = {10'($urandom_range(0, WORDS - 1)), 6'd0};
         1:       tgt = {10'($urandom_range(0, WORDS - 1)), 6'd63};
         default: tgt = 16'($urandom_range(0, 65535));
      endcase
      base = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 1000) : $urandom;
      ask(tgt, 16'($urandom), base);
   endtask

   // receiver: own stall pattern, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (mode_left == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         mode_left = $urandom_range(20, 300);
      end else begin
         mode_left--;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            RX_OPEN:     rsp_tready <= 1'b1;
            RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rsp_tready <= 1'(mode_left[2]);
            default:     rsp_tready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      successor_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hits.size() == 0) begin
            $error("result word with no query waiting: doc %h rank %h found %b",
                   rsp_tdata[31:0], rsp_tdata[63:32], rsp_tuser[0]);
            fail_count++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_tuser[0] !== want.found) begin
               $error("found: expected %b, actual %b", want.found, rsp_tuser[0]);
               fail_count++;
            end
            if (rsp_tdata[31:0] !== want.doc) begin
               $error("doc: expected %h, actual %h", want.doc, rsp_tdata[31:0]);
               fail_count++;
            end
            if (rsp_tdata[63:32] !== want.rank) begin
               $error("rank: expected %h, actual %h", want.rank, rsp_tdata[63:32]);
               fail_count++;
            end
         end
      end
   end

   // fill the whole block: full group, isolated edge bits, a long empty run, empty tail
   task automatic test_initial_load();
      int w;
      logic [63:0] value;
      for (w = 0; w < WORDS; w++) begin
         if (w < 8)
            value = '1;
         else if (w == 8)
            value = '0;
         else if (w == 16)
            value = 64'h8000_0000_0000_0000;
         else if (w == 17)
            value = 64'h1;
         else if (w < 200)
            value = shaped_word(($urandom_range(0, 1) == 0) ? WK_DENSE : WK_SPARSE);
         else if (w <= 700)
            value = '0;
         else if (w == 701)
            value = 64'h0000_0100_0000_0000;
         else if (w <= 1000)
            value = shaped_word(any_kind());
         else
            value = '0;
         put_load(value);
      end
   endtask

   task automatic test_directed_queries();
      ask(16'd0, 16'd0, 32'd0);
      ask(16'(8 * 64), 16'd3, 32'd100);
      ask(16'(16 * 64), 16'd1, 32'd5);
      ask(16'(16 * 64 + 63), 16'd2, 32'd7);
      ask(16'(17 * 64), 16'd9, 32'd0);
      ask(16'(17 * 64 + 1), 16'd9, 32'd0);
      ask(16'(7 * 64 + 63), 16'hFFFF, 32'hFFFF_FFFF);
      ask(16'(200 * 64), 16'h8000, 32'h1234_5678);
      ask(16'(701 * 64 + 40), 16'h0001, 32'hFFFF_FF00);
      ask(16'(701 * 64 + 41), 16'h0002, 32'd0);
      ask(16'(1001 * 64), 16'h5555, 32'hAAAA_AAAA);
      ask(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
      ask(16'(702 * 64), 16'hAAAA, 32'h5555_5555);
      repeat (6) ask_random();
   endtask

   // runs of loads interleaved with runs of queries over the partly rewritten block
   task automatic test_random_traffic();
      int items;
      int n;
      items = 0;
      while (items < RANDOM_MIX) begin
         n = $urandom_range(0, 12);
         repeat (n) put_load(shaped_word(any_kind()));
         items += n;
         n = $urandom_range(1, 6);
         repeat (n) ask_random();
         items += n;
      end
   endtask

   // the block is full: the next loads restart the count at word 0 of a new block
   task automatic test_wrap_around();
      put_load('1);
      put_load(shaped_word(WK_DENSE));
      ask(16'd0, 16'd1, 32'd0);
      ask(16'd64, 16'd1, 32'd0);
      ask(16'd128, 16'd1, 32'd0);
      ask(16'(9 * 64), 16'h1234, $urandom);
      repeat (4) ask_random();
   endtask

   task automatic test_backpressure();
      int i;
      hold_request = 1500;
      for (i = 0; i < 24; i++) begin
         if (i % 4 == 3)
            put_load(shaped_word(any_kind()));
         else
            ask_random();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_initial_load();
      test_directed_queries();
      test_wrap_around();
      test_random_traffic();
      test_backpressure();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      while (pending_hits.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("Loaded %0d words (%0d block starts), asked %0d successor queries:",
               loads_sent, wraps_seen, queries_sent);
      $display("%0d hits, %0d misses; long empty scans, rank wrap, block restart, long stall.",
               hits_seen, queries_sent - hits_seen);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
